>>> rtl/twwd_pkg.sv
// Package for the task window watchdog: channel payload structs, table entry
// layout, operating mode codes and the constants of the window arithmetic.
// No dependencies.
package twwd_pkg;

	localparam int NUM_TASKS_DEF = 8;

	localparam int MODE_W   = 2;
	localparam int INDEX_W  = 4;
	localparam int RUN_MS_W = 16;
	localparam int PERIOD_W = 24;
	localparam int PCT_W    = 8;
	localparam int RT_W     = 32;
	localparam int MASK_W   = 8;
	localparam int TICK_W   = 8;

	localparam logic [TICK_W-1:0] CHECK_TICKS_RST = 8'd4;

	localparam logic [MODE_W-1:0] MODE_REPORT   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_TICK     = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SET      = 2'd2;
	localparam logic [MODE_W-1:0] MODE_INACTIVE = 2'd3;

	// period / 100 is computed as (period * RECIP_100) >> RECIP_SHIFT. The
	// reciprocal overshoots 2^32/100 by 4/100, and 4 * 2^24 < 2^32 keeps the
	// quotient exact for every 24-bit period.
	localparam int RECIP_W     = 26;
	localparam int RECIP_SHIFT = 32;
	localparam logic [RECIP_W-1:0] RECIP_100 = 26'd42949673;
	localparam int PROD_W      = PERIOD_W + RECIP_W;
	localparam int UNIT_W      = PROD_W - RECIP_SHIFT;
	localparam int WIN_W       = UNIT_W + PCT_W;

	typedef struct packed {
		logic [MODE_W-1:0]   mode;
		logic [INDEX_W-1:0]  task_index;
		logic [RUN_MS_W-1:0] run_ms;
		logic [PERIOD_W-1:0] period_ms;
		logic [PCT_W-1:0]    min_pct;
		logic [PCT_W-1:0]    max_pct;
		logic                inactive_flag;
	} cmd_t;

	typedef struct packed {
		logic                kick;
		logic                check_done;
		logic                failed;
		logic [INDEX_W-1:0]  fail_index;
		logic [RT_W-1:0]     fail_run_time;
		logic [MASK_W-1:0]   suspended_mask;
		logic                bad_index;
	} res_t;

	typedef struct packed {
		logic [RT_W-1:0]     accum;
		logic [PERIOD_W-1:0] period;
		logic [PCT_W-1:0]    min_pct;
		logic [PCT_W-1:0]    max_pct;
		logic                inactive;
	} entry_t;

endpackage

>>> rtl/twwd_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module twwd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/task_window_watchdog_core.sv
// Task window watchdog core: top level with the control sequencer, the window
// arithmetic and the result register. Depends on twwd_pkg and twwd_ram.
//
// The block monitors a table of NUM_TASKS tasks held in one RAM word per task
// (run-time accumulator, period, window percentages, inactive flag). A command
// transfer either adds reported run time to an entry (saturating), writes an
// entry's settings, writes its inactive flag, or delivers a half-timeout tick.
// Every tick before a failure asks for a watchdog kick; every check_ticks ticks
// the tick also walks the table and tests each accumulator against the window
// [(period/100)*min_pct, (period/100)*max_pct]. Passing or inactive entries are
// cleared, inactive entries that were outside the window show up in
// suspended_mask, and the first active entry outside its window ends the walk
// and latches a sticky failure that freezes the block until reset. Each command
// yields exactly one result transfer. Commands are handled one at a time: a
// report, set or inactive command passes through RD and UPD to DONE, a tick
// without a check or a command with a bad index or arriving after failure goes
// straight to DONE, and a tick that checks passes each entry in turn through
// RD, MUL1, MUL2 and CMP: the RAM read, the two multiply stages and the
// write-back. The result register lets the next command be taken while the
// previous result still waits on res_ready. The table is reset to zero through
// per-entry valid flops, so no clearing pass is needed.
module task_window_watchdog_core
	import twwd_pkg::*;
#(
	parameter int NUM_TASKS = NUM_TASKS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              check_ticks_we,
	input  logic [TICK_W-1:0] check_ticks_wdata,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  cmd_t              cmd,
	output logic              res_valid,
	input  logic              res_ready,
	output res_t              res
);

	localparam int AW    = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
	localparam int ENT_W = $bits(entry_t);
	localparam logic [AW-1:0] LAST_IDX = AW'(NUM_TASKS - 1);
	localparam logic [INDEX_W:0] NUM_TASKS_X = (INDEX_W+1)'(NUM_TASKS);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_UPD  = 3'd2;
	localparam logic [2:0] ST_MUL1 = 3'd3;
	localparam logic [2:0] ST_MUL2 = 3'd4;
	localparam logic [2:0] ST_CMP  = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	logic [2:0] state_q;

	// Configuration and sticky status.
	logic [TICK_W-1:0]  check_ticks_q;
	logic [TICK_W-1:0]  tick_count_q;
	logic               failed_q;
	logic [INDEX_W-1:0] fail_index_q;
	logic [RT_W-1:0]    fail_rt_q;

	// Per-command context.
	cmd_t               cmd_q;
	logic               walk_q;
	logic [AW-1:0]      idx_q;
	logic               kick_q;
	logic               done_q;
	logic               bad_q;
	logic [MASK_W-1:0]  mask_q;

	// Valid bit per table entry; an entry never written reads as all zero.
	logic [NUM_TASKS-1:0] valid_q;
	logic                 rd_valid_s1;

	// Window pipeline.
	entry_t             ent_s1;
	logic [UNIT_W-1:0]  unit_s1;
	logic [WIN_W-1:0]   lo_s2;
	logic [WIN_W-1:0]   hi_s2;

	// RAM port.
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	entry_t             ram_wdata;
	logic               ram_re;
	logic [ENT_W-1:0]   ram_rdata;
	entry_t             ent_rd;

	res_t               res_q;
	logic               res_valid_q;

	logic               accept;
	logic               out_free;
	logic               idx_bad;
	logic [TICK_W-1:0]  tick_next;
	logic               check_now;
	logic [PROD_W-1:0]  unit_prod;
	logic [RT_W:0]      rt_sum;
	logic               in_window;

	twwd_ram #(
		.WIDTH(ENT_W),
		.DEPTH(NUM_TASKS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	assign cmd_ready = (state_q == ST_IDLE);
	assign accept    = cmd_valid && cmd_ready;
	assign out_free  = !res_valid_q || res_ready;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign idx_bad   = {1'b0, cmd.task_index} >= NUM_TASKS_X;
	assign tick_next = tick_count_q + TICK_W'(1);
	assign check_now = tick_next >= check_ticks_q;

	assign ram_re    = (state_q == ST_RD);
	assign ent_rd    = rd_valid_s1 ? entry_t'(ram_rdata) : '0;
	assign unit_prod = PROD_W'(ent_rd.period) * PROD_W'(RECIP_100);
	assign rt_sum    = {1'b0, ent_rd.accum} + (RT_W+1)'(cmd_q.run_ms);
	assign in_window = (ent_s1.accum >= RT_W'(lo_s2)) &&
	                   (ent_s1.accum <= RT_W'(hi_s2));

	// Write-back: single-entry commands modify the word just read; the walk
	// clears the accumulator of an entry that passed or is inactive.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = ent_s1;
		if (state_q == ST_UPD) begin
			ram_we    = 1'b1;
			ram_wdata = ent_rd;
			case (cmd_q.mode)
				MODE_REPORT: begin
					ram_wdata.accum = rt_sum[RT_W] ? '1 : rt_sum[RT_W-1:0];
				end
				MODE_SET: begin
					ram_wdata.period   = cmd_q.period_ms;
					ram_wdata.min_pct  = cmd_q.min_pct;
					ram_wdata.max_pct  = cmd_q.max_pct;
					ram_wdata.inactive = 1'b0;
				end
				default: begin
					ram_wdata.inactive = cmd_q.inactive_flag;
				end
			endcase
		end else if (state_q == ST_CMP) begin
			ram_we          = in_window || ent_s1.inactive;
			ram_wdata       = ent_s1;
			ram_wdata.accum = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_ticks_q <= CHECK_TICKS_RST;
		end else if (check_ticks_we) begin
			check_ticks_q <= check_ticks_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ram_we) begin
			valid_q[ram_waddr] <= 1'b1;
		end
	end

	// Sequencer. A command is latched at its transfer; a tick that checks
	// runs RD, MUL1, MUL2, CMP once per entry and stops at the first failure.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			tick_count_q <= '0;
			failed_q     <= 1'b0;
			fail_index_q <= '0;
			fail_rt_q    <= '0;
			walk_q       <= 1'b0;
			idx_q        <= '0;
			kick_q       <= 1'b0;
			done_q       <= 1'b0;
			bad_q        <= 1'b0;
			mask_q       <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						kick_q <= 1'b0;
						done_q <= 1'b0;
						bad_q  <= 1'b0;
						mask_q <= '0;
						walk_q <= 1'b0;
						idx_q  <= '0;
						state_q <= ST_DONE;
						if (!failed_q) begin
							if (cmd.mode == MODE_TICK) begin
								kick_q <= 1'b1;
								if (check_now) begin
									tick_count_q <= '0;
									done_q       <= 1'b1;
									walk_q       <= 1'b1;
									state_q      <= ST_RD;
								end else begin
									tick_count_q <= tick_next;
								end
							end else if (idx_bad) begin
								bad_q <= 1'b1;
							end else begin
								idx_q   <= cmd.task_index[AW-1:0];
								state_q <= ST_RD;
							end
						end
					end
				end
				ST_RD: begin
					state_q <= walk_q ? ST_MUL1 : ST_UPD;
				end
				ST_UPD: begin
					state_q <= ST_DONE;
				end
				ST_MUL1: begin
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (in_window || ent_s1.inactive) begin
						if (!in_window) begin
							mask_q <= mask_q | (MASK_W'(1) << idx_q);
						end
						if (idx_q == LAST_IDX) begin
							state_q <= ST_DONE;
						end else begin
							idx_q   <= idx_q + AW'(1);
							state_q <= ST_RD;
						end
					end else begin
						failed_q     <= 1'b1;
						fail_index_q <= INDEX_W'(idx_q);
						fail_rt_q    <= ent_s1.accum;
						state_q      <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
		end
		if (ram_re) begin
			rd_valid_s1 <= valid_q[idx_q];
		end
		if (state_q == ST_MUL1) begin
			ent_s1  <= ent_rd;
			unit_s1 <= unit_prod[PROD_W-1:RECIP_SHIFT];
		end
		if (state_q == ST_MUL2) begin
			lo_s2 <= WIN_W'(unit_s1) * WIN_W'(ent_s1.min_pct);
			hi_s2 <= WIN_W'(unit_s1) * WIN_W'(ent_s1.max_pct);
		end
	end

	// Result register: loaded once per command, freeing the sequencer to take
	// the next command transfer while this result waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			res_q.kick           <= kick_q;
			res_q.check_done     <= done_q;
			res_q.failed         <= failed_q;
			res_q.fail_index     <= fail_index_q;
			res_q.fail_run_time  <= fail_rt_q;
			res_q.suspended_mask <= mask_q;
			res_q.bad_index      <= bad_q;
		end
	end

	// The failure latch never clears once set.
	a_failed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		failed_q |=> failed_q)
		else $error("failure latch cleared");

	// The table is only written while a command is being worked on.
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_DONE) |-> !ram_we)
		else $error("table write outside command processing");

	// A rejected index never comes with a kick or a check.
	a_bad_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.bad_index) |-> (!res_q.kick && !res_q.check_done))
		else $error("bad index result carries tick flags");

	// Suspended entries are reported only by a check.
	a_mask_check: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_q.check_done) |-> (res_q.suspended_mask == '0))
		else $error("suspended mask without a check");

endmodule

>>> verif/testbench.sv
// Self-checking testbench for task_window_watchdog_core: drives command transfers,
// predicts every result with a table model of its own and checks each result field.
// Depends on twwd_pkg and the RTL of the core.
`timescale 1ns / 1ps

module testbench;
	import twwd_pkg::*;

	localparam int TASKS = NUM_TASKS_DEF;
	// Roughly 850 commands under full idling and checking ticks; the limit
	// leaves several times the cycles that they need.
	localparam int CYCLE_LIMIT = 200_000;
	// A checking tick walks every entry through the RAM and both multiplier
	// stages, which is the longest a single command can keep the core busy.
	localparam int FULL_CHECK_CYCLES = 4 * TASKS + 2;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              check_ticks_we = 1'b0;
	logic [TICK_W-1:0] check_ticks_wdata = '0;
	logic              cmd_valid = 1'b0;
	logic              cmd_ready;
	cmd_t              cmd = '0;
	logic              res_valid;
	logic              res_ready = 1'b0;
	res_t              res;

	// Percent of cycles in which each side idles; zero during the bursts.
	int send_idle_pct = 32;
	int recv_idle_pct = 32;
	int mismatches = 0;
	int cycle_count = 0;

	// Results the core still owes, oldest first.
	res_t expected_results[$];
	res_t oldest_expected;

	// Watchdog table as the testbench sees it, updated at each accepted transfer.
	logic [RT_W-1:0]     acc_ms       [TASKS] = '{default: '0};
	logic [PERIOD_W-1:0] period_tbl   [TASKS] = '{default: '0};
	logic [PCT_W-1:0]    min_tbl      [TASKS] = '{default: '0};
	logic [PCT_W-1:0]    max_tbl      [TASKS] = '{default: '0};
	logic                inactive_tbl [TASKS] = '{default: 1'b0};
	logic [TICK_W-1:0]   ticks_seen = '0;
	logic [TICK_W-1:0]   ticks_per_check = CHECK_TICKS_RST;
	logic                wd_failed = 1'b0;
	logic [INDEX_W-1:0]  fail_idx = '0;
	logic [RT_W-1:0]     fail_acc = '0;

	task_window_watchdog_core uut (
		.clk               (clk),
		.arst_n            (arst_n),
		.check_ticks_we    (check_ticks_we),
		.check_ticks_wdata (check_ticks_wdata),
		.cmd_valid         (cmd_valid),
		.cmd_ready         (cmd_ready),
		.cmd               (cmd),
		.res_valid         (res_valid),
		.res_ready         (res_ready),
		.res               (res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Window edge of an entry: the period is first cut to whole percent units,
	// so the rounding loss of period / 100 scales with the percentage.
	function automatic logic [RT_W-1:0] window_edge(int i, logic [PCT_W-1:0] pct);
		return (period_tbl[i] / 100) * pct;
	endfunction

	function automatic logic entry_in_window(int i);
		return acc_ms[i] >= window_edge(i, min_tbl[i]) && acc_ms[i] <= window_edge(i, max_tbl[i]);
	endfunction

	// Applies one accepted command to the table and returns the result the core
	// must give for it.
	function automatic res_t watchdog_predict(cmd_t c);
		res_t            r;
		int              i;
		logic            halt;
		logic [RT_W:0]   sum;
		r = '0;
		halt = 1'b0;
		// Once the failure is latched the core ignores everything it gets.
		if (!wd_failed) begin
			if (c.mode == MODE_TICK) begin
				r.kick = 1'b1;
				ticks_seen = ticks_seen + 1'b1;
				if (ticks_seen >= ticks_per_check) begin
					ticks_seen = '0;
					r.check_done = 1'b1;
					// The walk ends at the first active entry outside its window;
					// entries after it are neither tested nor cleared.
					for (i = 0; i < TASKS && !halt; i++) begin
						if (entry_in_window(i)) begin
							acc_ms[i] = '0;
						end else if (inactive_tbl[i]) begin
							if (i < MASK_W)
								r.suspended_mask[i] = 1'b1;
							acc_ms[i] = '0;
						end else begin
							wd_failed = 1'b1;
							fail_idx = INDEX_W'(i);
							fail_acc = acc_ms[i];
							halt = 1'b1;
						end
					end
				end
			end else if (c.task_index >= TASKS) begin
				r.bad_index = 1'b1;
			end else begin
				case (c.mode)
					MODE_REPORT: begin
						sum = acc_ms[c.task_index] + c.run_ms;
						acc_ms[c.task_index] = sum[RT_W] ? '1 : sum[RT_W-1:0];
					end
					MODE_SET: begin
						period_tbl[c.task_index] = c.period_ms;
						min_tbl[c.task_index] = c.min_pct;
						max_tbl[c.task_index] = c.max_pct;
						inactive_tbl[c.task_index] = 1'b0;
					end
					MODE_INACTIVE: begin
						inactive_tbl[c.task_index] = c.inactive_flag;
					end
					default: ;
				endcase
			end
		end
		r.failed = wd_failed;
		r.fail_index = fail_idx;
		r.fail_run_time = fail_acc;
		return r;
	endfunction

	// Every field is random unless the caller overrides it, so fields that the
	// mode does not use still toggle.
	function automatic cmd_t make_cmd(logic [MODE_W-1:0] mode, int idx);
		cmd_t c;
		c.mode = mode;
		c.task_index = INDEX_W'(idx);
		c.run_ms = RUN_MS_W'($urandom);
		c.period_ms = PERIOD_W'($urandom);
		c.min_pct = PCT_W'($urandom);
		c.max_pct = PCT_W'($urandom);
		c.inactive_flag = 1'($urandom);
		return c;
	endfunction

	function automatic cmd_t report_cmd(int idx, int ms);
		cmd_t c;
		c = make_cmd(MODE_REPORT, idx);
		c.run_ms = RUN_MS_W'(ms);
		return c;
	endfunction

	function automatic cmd_t set_cmd(int idx, int period, int mn, int mx);
		cmd_t c;
		c = make_cmd(MODE_SET, idx);
		c.period_ms = PERIOD_W'(period);
		c.min_pct = PCT_W'(mn);
		c.max_pct = PCT_W'(mx);
		return c;
	endfunction

	function automatic cmd_t flag_cmd(int idx, bit flag);
		cmd_t c;
		c = make_cmd(MODE_INACTIVE, idx);
		c.inactive_flag = flag;
		return c;
	endfunction

	// Presents one command and holds it until the transfer. Valid stays high
	// into the next command unless the sender decides to idle, and an idle
	// always waits on the clock before the next command, so valid is never
	// lowered and raised in the same time step.
	task automatic send_cmd(cmd_t c);
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (!cmd_ready);
		expected_results.push_back(watchdog_predict(c));
		if ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
	endtask

	// Stops sending and waits until every owed result has been taken.
	task automatic drain_results();
		cmd_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	// The register is only written with the core idle.
	task automatic write_check_ticks(int value);
		drain_results();
		check_ticks_we <= 1'b1;
		check_ticks_wdata <= TICK_W'(value);
		@(posedge clk);
		check_ticks_we <= 1'b0;
		ticks_per_check = TICK_W'(value);
	endtask

	// Sends a tick. When keep_healthy is set and the tick is going to walk the
	// table, every active entry outside its window is first brought back into
	// it (by topping it up to the lower edge) or marked inactive, so the sticky
	// failure is kept for the last test.
	task automatic send_tick(bit keep_healthy);
		logic [TICK_W-1:0] next_count;
		logic [RT_W-1:0]   lo;
		logic [RT_W-1:0]   hi;
		int                i;
		next_count = ticks_seen + 1'b1;
		if (keep_healthy && !wd_failed && next_count >= ticks_per_check) begin
			for (i = 0; i < TASKS; i++) begin
				if (!inactive_tbl[i] && !entry_in_window(i)) begin
					lo = window_edge(i, min_tbl[i]);
					hi = window_edge(i, max_tbl[i]);
					if (acc_ms[i] < lo && lo <= hi && lo - acc_ms[i] <= 32'hFFFF)
						send_cmd(report_cmd(i, lo - acc_ms[i]));
					else
						send_cmd(flag_cmd(i, 1'b1));
				end
			end
		end
		send_cmd(make_cmd(MODE_TICK, $urandom_range(15)));
	endtask

	// Mostly well-formed traffic on valid entries, with windows that reports
	// can land in, plus a share of commands aimed past the end of the table.
	task automatic run_random(int count);
		cmd_t c;
		int   pick;
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < 25) begin
				send_tick(1'b1);
			end else begin
				if (pick < 55) begin
					c = make_cmd(MODE_REPORT, $urandom_range(TASKS - 1));
					if ($urandom_range(1))
						c.run_ms = RUN_MS_W'($urandom_range(400));
				end else if (pick < 70) begin
					c = make_cmd(MODE_SET, $urandom_range(TASKS - 1));
					if ($urandom_range(1))
						c.period_ms = PERIOD_W'($urandom_range(20000));
					if ($urandom_range(9) < 7) begin
						c.min_pct = PCT_W'($urandom_range(100));
						c.max_pct = PCT_W'($urandom_range(255, 100));
					end
				end else if (pick < 82) begin
					c = make_cmd(MODE_INACTIVE, $urandom_range(TASKS - 1));
				end else begin
					c = make_cmd(MODE_REPORT, $urandom_range(15, TASKS));
					case ($urandom_range(2))
						0: c.mode = MODE_REPORT;
						1: c.mode = MODE_SET;
						default: c.mode = MODE_INACTIVE;
					endcase
				end
				send_cmd(c);
			end
		end
	endtask

	// Field extremes, each mode, bad indexes, an empty window, an inverted
	// window, exact window edges and the reset interval of four ticks.
	task automatic test_directed_cases();
		send_tick(1'b0);
		send_cmd(report_cmd(0, 0));
		send_cmd(report_cmd(8, 'hFFFF));
		send_cmd(set_cmd(15, 'hFFFFFF, 'hFF, 'hFF));
		send_cmd(flag_cmd(9, 1'b1));
		send_cmd(set_cmd(0, 'hFFFFFF, 0, 'hFF));
		send_cmd(report_cmd(0, 'hFFFF));
		send_cmd(set_cmd(7, 0, 'hFF, 0));
		send_cmd(report_cmd(7, 'hFFFF));
		send_cmd(flag_cmd(7, 1'b1));
		// Lower edge above the upper edge: no run time can pass.
		send_cmd(set_cmd(1, 1000, 50, 40));
		send_cmd(flag_cmd(1, 1'b1));
		// Period below 100 gives a window of exactly zero.
		send_cmd(set_cmd(2, 99, 10, 10));
		send_cmd(set_cmd(3, 200, 100, 100));
		send_cmd(report_cmd(3, 200));
		send_cmd(flag_cmd(4, 1'b0));
		// Fourth tick since reset walks the table and flags entries 1 and 7.
		repeat (3) send_tick(1'b0);
		send_cmd(set_cmd(1, 0, 0, 0));
		send_cmd(flag_cmd(7, 1'b0));
	endtask

	// Largest interval: the 255th tick checks. The ticks left counted after
	// it make the next phase start with a count above its new interval.
	task automatic test_longest_interval();
		write_check_ticks(255);
		repeat (255) begin
			send_tick(1'b1);
			if ($urandom_range(7) == 0)
				send_cmd(report_cmd($urandom_range(TASKS - 1), $urandom_range(300)));
		end
		repeat (20) send_tick(1'b1);
	endtask

	// Smallest interval, then zero, where every tick walks the table.
	task automatic test_random_intervals();
		write_check_ticks(1);
		run_random(100);
		write_check_ticks(0);
		run_random(100);
	endtask

	// A long stretch with neither side idling.
	task automatic test_back_to_back();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_check_ticks($urandom_range(254, 2));
		run_random(150);
		send_idle_pct = 32;
		recv_idle_pct = 32;
	endtask

	// The sender stops halfway and waits for the core to return every result.
	task automatic test_sender_pause();
		write_check_ticks(3);
		run_random(60);
		drain_results();
		run_random(60);
	endtask

	// Drives one accumulator far past its window, lets the walk fail on it and
	// then checks that the core stays frozen. This must be the last test,
	// since the failure holds until reset.
	task automatic test_sticky_failure();
		int i;
		write_check_ticks(1);
		for (i = 0; i < 5; i++)
			send_cmd(flag_cmd(i, 1'b1));
		// Writing the settings must clear the inactive flag again, otherwise
		// the walk would not fail on this entry.
		send_cmd(flag_cmd(5, 1'b1));
		send_cmd(set_cmd(5, 100, 0, 255));
		// Full-size reports put the accumulator far above the upper edge.
		repeat (4) send_cmd(report_cmd(5, 'hFFFF));
		send_tick(1'b0);
		send_cmd(report_cmd(0, 'hFFFF));
		send_cmd(report_cmd(12, 1));
		send_cmd(set_cmd(2, 5000, 10, 90));
		send_cmd(set_cmd(8, 5000, 10, 90));
		send_cmd(flag_cmd(3, 1'b1));
		send_cmd(flag_cmd(14, 1'b0));
		repeat (2) send_tick(1'b0);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_longest_interval();
		test_random_intervals();
		test_back_to_back();
		test_sender_pause();
		test_sticky_failure();
		drain_results();
		// Allow a stray result to show up before the verdict.
		repeat (FULL_CHECK_CYCLES + 8) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	always @(posedge clk) begin
		res_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endfunction

	// Every result transfer is matched against the oldest owed result.
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			if (expected_results.size() == 0) begin
				$error("result transfer with no command waiting for it");
				mismatches++;
			end else begin
				oldest_expected = expected_results.pop_front();
				compare_field("kick", oldest_expected.kick, res.kick);
				compare_field("check_done", oldest_expected.check_done, res.check_done);
				compare_field("failed", oldest_expected.failed, res.failed);
				compare_field("fail_index", oldest_expected.fail_index, res.fail_index);
				compare_field("fail_run_time", oldest_expected.fail_run_time,
					res.fail_run_time);
				compare_field("suspended_mask", oldest_expected.suspended_mask,
					res.suspended_mask);
				compare_field("bad_index", oldest_expected.bad_index, res.bad_index);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

endmodule

>>> files.f
rtl/twwd_pkg.sv
rtl/twwd_ram.sv
rtl/task_window_watchdog_core.sv
verif/testbench.sv
